[hdl/drm_pkg.sv]
package drm_pkg;

   localparam int CHAR_BITS    = 16;
   localparam int MAX_SEQ      = 4;
   localparam int SEQ_IDX_BITS = $clog2(MAX_SEQ);
   localparam int SEQ_LEN_BITS = $clog2(MAX_SEQ + 1);
   localparam int SEQ_BITS     = 64;
   localparam int MAX_LINE_VAL = 4096;
   localparam int LEN_BITS     = $clog2(MAX_LINE_VAL + 1);
   localparam logic [LEN_BITS-1:0] MAX_LINE = LEN_BITS'(MAX_LINE_VAL);

   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 64;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_START_SEQ     = 3'd0,
      CSR_START_LEN     = 3'd1,
      CSR_END_SEQ       = 3'd2,
      CSR_END_LEN       = 3'd3,
      CSR_ESCAPE_ENABLE = 3'd4,
      CSR_ESCAPE_CHAR   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_START  = 2'd1,
      PH_SEARCH = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      logic                 first_char;
      logic [CHAR_BITS-1:0] prev_char;
      logic                 has_prev;
      logic                 line_end;
   } req_type;

   typedef struct packed {
      logic                matched;
      logic [LEN_BITS-1:0] region_length;
   } rsp_type;

   typedef logic [MAX_SEQ-1:0][CHAR_BITS-1:0] window_type;

   typedef struct packed {
      window_type           recent;
      logic [MAX_SEQ-1:0]   cand_ok;
      logic [SEQ_LEN_BITS-1:0] end_len;
   } end_probe_type;

   function automatic logic [CHAR_BITS-1:0] seq_char(input logic [SEQ_BITS-1:0] seq,
                                                     input logic [SEQ_IDX_BITS-1:0] k);
      return seq[k*CHAR_BITS +: CHAR_BITS];
   endfunction

   function automatic logic [SEQ_LEN_BITS-1:0] clamp_len(input logic [2:0] v,
                                                         input logic [SEQ_LEN_BITS-1:0] lo);
      logic [SEQ_LEN_BITS-1:0] r;
      if (v < 3'(lo)) r = lo;
      else if (v > 3'(MAX_SEQ)) r = SEQ_LEN_BITS'(MAX_SEQ);
      else r = SEQ_LEN_BITS'(v);
      return r;
   endfunction

endpackage

[hdl/delimited_region_matcher.sv]
// Delimited region matcher. Feed the characters of a line one item per clock, starting at
// the candidate position with first_char set (prev_char and has_prev describe the character
// before it). The block checks the start sequence, refuses the match when the preceding
// character is the enabled escape character, then searches for the end sequence with escape
// handling and returns one rsp item per run: matched and the region length, saturating at
// 4096. Throughput is one character per clock while the result register is not stalled; a
// character goes through an input register and the match logic into the result register.
// Registers on the csr port are written with no wait states and must be written only while
// no run is in progress.
module delimited_region_matcher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  drm_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output drm_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [drm_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [drm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // configuration
   logic [drm_pkg::SEQ_BITS-1:0]  start_seq_ff;
   logic [2:0]                    start_len_ff;
   logic [drm_pkg::SEQ_BITS-1:0]  end_seq_ff;
   logic [2:0]                    end_len_ff;
   logic                          escape_enable_ff;
   logic [drm_pkg::CHAR_BITS-1:0] escape_char_ff;

   // input register
   logic             in_valid_ff, in_valid_in;
   drm_pkg::req_type in_ff;

   // run state
   drm_pkg::phase_type            phase_ff, phase_in;
   logic [drm_pkg::LEN_BITS-1:0]  count_ff, count_in;
   drm_pkg::window_type           recent_ff, recent_in;
   logic [drm_pkg::MAX_SEQ-1:0]   cand_ff, cand_in;
   logic                          skip_ff, skip_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   drm_pkg::rsp_type rsp_ff, rsp_in;

   logic                              advance, fire;
   logic [drm_pkg::SEQ_LEN_BITS-1:0]  slen, elen;
   logic                              refuse, is_esc;
   drm_pkg::phase_type                cur_phase;
   logic [drm_pkg::LEN_BITS-1:0]      cur_count, count_next;
   drm_pkg::window_type               cur_recent, recent_next;
   logic [drm_pkg::MAX_SEQ-1:0]       cur_cand, cand_search;
   logic                              cur_skip, cand_bit;
   logic                              start_ok, start_more, hit;
   logic                              emit;
   drm_pkg::end_probe_type            probe;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_seq_ff     <= '0;
         start_len_ff     <= 3'd1;
         end_seq_ff       <= '0;
         end_len_ff       <= '0;
         escape_enable_ff <= 1'b0;
         escape_char_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            drm_pkg::CSR_START_SEQ:     start_seq_ff     <= csr_wdata;
            drm_pkg::CSR_START_LEN:     start_len_ff     <= csr_wdata[2:0];
            drm_pkg::CSR_END_SEQ:       end_seq_ff       <= csr_wdata;
            drm_pkg::CSR_END_LEN:       end_len_ff       <= csr_wdata[2:0];
            drm_pkg::CSR_ESCAPE_ENABLE: escape_enable_ff <= csr_wdata[0];
            drm_pkg::CSR_ESCAPE_CHAR:   escape_char_ff   <= csr_wdata[drm_pkg::CHAR_BITS-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !in_valid_ff || advance;
   assign fire        = in_valid_ff && advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // state as seen by the current item
   always_comb begin
      slen   = drm_pkg::clamp_len(start_len_ff, drm_pkg::SEQ_LEN_BITS'(1));
      elen   = drm_pkg::clamp_len(end_len_ff, '0);
      is_esc = escape_enable_ff && (in_ff.ch == escape_char_ff);
      refuse = in_ff.first_char && escape_enable_ff && in_ff.has_prev &&
               (in_ff.prev_char == escape_char_ff);
      if (in_ff.first_char) begin
         cur_phase  = drm_pkg::PH_START;
         cur_count  = '0;
         cur_recent = '0;
         cur_cand   = '0;
         cur_skip   = 1'b0;
      end else begin
         cur_phase  = phase_ff;
         cur_count  = count_ff;
         cur_recent = recent_ff;
         cur_cand   = cand_ff;
         cur_skip   = skip_ff;
      end
      count_next  = (cur_count < drm_pkg::MAX_LINE) ? cur_count + 1'b1 : cur_count;
      recent_next = {cur_recent[drm_pkg::MAX_SEQ-2:0], in_ff.ch};
      cand_bit    = !cur_skip;
      cand_search = {cur_cand[drm_pkg::MAX_SEQ-2:0], cand_bit && !is_esc};
      start_ok    = in_ff.ch == drm_pkg::seq_char(start_seq_ff,
                                                 cur_count[drm_pkg::SEQ_IDX_BITS-1:0]);
      start_more  = (cur_count + 1'b1) < drm_pkg::LEN_BITS'(slen);
   end

   assign probe.recent  = recent_next;
   assign probe.cand_ok = cand_search;
   assign probe.end_len = elen;

   drm_end_detect u_end_detect (
      .probe   (probe),
      .end_seq (end_seq_ff),
      .hit     (hit)
   );

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (refuse) begin
            phase_in = drm_pkg::PH_IDLE;
         end else begin
            unique case (cur_phase)
               drm_pkg::PH_IDLE: phase_in = drm_pkg::PH_IDLE;
               drm_pkg::PH_START: begin
                  if (!start_ok || in_ff.line_end) phase_in = drm_pkg::PH_IDLE;
                  else if (start_more) phase_in = drm_pkg::PH_START;
                  else phase_in = drm_pkg::PH_SEARCH;
               end
               drm_pkg::PH_SEARCH: begin
                  if (in_ff.line_end || (elen != '0 && hit)) phase_in = drm_pkg::PH_IDLE;
                  else phase_in = drm_pkg::PH_SEARCH;
               end
               default: phase_in = drm_pkg::PH_IDLE;
            endcase
         end
      end
   end

   // datapath and result
   always_comb begin
      count_in  = count_ff;
      recent_in = recent_ff;
      cand_in   = cand_ff;
      skip_in   = skip_ff;
      emit      = 1'b0;
      rsp_in    = '0;
      if (fire) begin
         if (refuse) begin
            emit      = 1'b1;
            count_in  = '0;
            recent_in = '0;
            cand_in   = '0;
            skip_in   = 1'b0;
         end else if (cur_phase != drm_pkg::PH_IDLE) begin
            count_in  = count_next;
            recent_in = recent_next;
            cand_in   = cur_cand;
            skip_in   = cur_skip;
            unique case (cur_phase)
               drm_pkg::PH_START: begin
                  cand_in = {cur_cand[drm_pkg::MAX_SEQ-2:0], 1'b0};
                  if (!start_ok) begin
                     emit = 1'b1;
                  end else if (in_ff.line_end) begin
                     emit = 1'b1;
                     if (!start_more && elen == '0) begin
                        rsp_in.matched       = 1'b1;
                        rsp_in.region_length = count_next;
                     end
                  end
               end
               drm_pkg::PH_SEARCH: begin
                  if (elen == '0) begin
                     if (in_ff.line_end) begin
                        emit                 = 1'b1;
                        rsp_in.matched       = 1'b1;
                        rsp_in.region_length = count_next;
                     end
                  end else begin
                     cand_in = cand_search;
                     skip_in = cand_bit && is_esc;
                     if (hit) begin
                        emit                 = 1'b1;
                        rsp_in.matched       = 1'b1;
                        rsp_in.region_length = count_next;
                     end else if (in_ff.line_end) begin
                        emit = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= drm_pkg::PH_IDLE;
         count_ff     <= '0;
         recent_ff    <= '0;
         cand_ff      <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         recent_ff    <= recent_in;
         cand_ff      <= cand_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_nomatch_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.matched |-> rsp_ff.region_length == '0)
      else $error("no-match item carries a nonzero length");

   a_match_nonzero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.matched |-> rsp_ff.region_length != '0)
      else $error("matched item carries zero length");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= drm_pkg::MAX_LINE)
      else $error("character count beyond saturation");

   a_start_short: assert property (@(posedge clock) disable iff (reset)
      phase_ff == drm_pkg::PH_START |-> count_ff < drm_pkg::LEN_BITS'(drm_pkg::MAX_SEQ))
      else $error("start phase ran past the longest start sequence");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("stalled item lost from input register");

endmodule

[hdl/drm_end_detect.sv]
module drm_end_detect (
   input  drm_pkg::end_probe_type        probe,
   input  logic [drm_pkg::SEQ_BITS-1:0]  end_seq,
   output logic                          hit
);

   logic [drm_pkg::SEQ_IDX_BITS-1:0] last_pos;
   logic [drm_pkg::SEQ_IDX_BITS-1:0] pos;

   always_comb begin
      last_pos = drm_pkg::SEQ_IDX_BITS'(probe.end_len - 1'b1);
      pos      = '0;
      hit      = (probe.end_len != '0) && probe.cand_ok[last_pos];
      for (int i = 0; i < drm_pkg::MAX_SEQ; i++) begin
         pos = last_pos - drm_pkg::SEQ_IDX_BITS'(i);
         if (drm_pkg::SEQ_LEN_BITS'(i) < probe.end_len) begin
            if (probe.recent[pos] !=
                drm_pkg::seq_char(end_seq, drm_pkg::SEQ_IDX_BITS'(i))) begin
               hit = 1'b0;
            end
         end
      end
   end

endmodule
